// ----- src/bqr_pkg.sv -----
// ----------------------------------------------------------------------------
// bqr_pkg
// Shared types and constants for the ramped biquad: payload structs, register
// indexes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bqr_pkg;

    localparam int NUM_COEF = 5;
    // Ramp dividend width: |delta| * k stays below 2^46, plus rounding half
    localparam int DIV_W    = 47;
    localparam int CNT_W    = 6;

    // Configuration register indexes; ramp slots use the same numbering
    typedef enum logic [2:0] {
        REG_B0   = 3'd0,
        REG_B1   = 3'd1,
        REG_B2   = 3'd2,
        REG_A1   = 3'd3,
        REG_A2   = 3'd4,
        REG_GAIN = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [23:0] sample_in;
        logic [12:0]        block_length;
    } smp_item_t;

    typedef struct packed {
        logic signed [23:0] sample_out;
        logic               block_end;
    } res_item_t;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MS_RAMP,
        MS_CX,
        MS_CYH,
        MS_CYL,
        MS_GYH,
        MS_GYL
    } mul_sel_t;

    typedef enum logic [1:0] {
        TERM_HOLD,
        TERM_SET,
        TERM_SET_HI,
        TERM_ADD
    } term_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic [2:0] sel;
        logic     div_start;
        logic     div_step;
        logic     ramp_wb;
        logic     take_tgt;
        term_op_t term_op;
        acc_op_t  acc_op;
        logic     y_sat;
        logic     commit;
    } dp_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic last;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RMUL,
        ST_RDIV_LD,
        ST_RDIV,
        ST_RWB,
        ST_FMUL,
        ST_FTERM,
        ST_FACC,
        ST_YSAT,
        ST_OUT
    } state_t;

endpackage

// ----- src/bqr_div.sv -----
// ----------------------------------------------------------------------------
// bqr_div
// Restoring divider, one quotient bit per step. The quotient shifts into the
// dividend register from the right.
// ----------------------------------------------------------------------------
module bqr_div (
    input  logic                      clk,
    input  logic                      start,
    input  logic                      step,
    input  logic [bqr_pkg::DIV_W-1:0] dividend,
    input  logic [12:0]               divisor,
    output logic [bqr_pkg::DIV_W-1:0] quot
);

    logic [12:0]               rem_reg;
    logic [12:0]               rem_next;
    logic [bqr_pkg::DIV_W-1:0] dvd_reg;
    logic [bqr_pkg::DIV_W-1:0] dvd_next;
    logic [13:0]               rem_sh;
    logic                      ge;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[bqr_pkg::DIV_W-1]};
        ge       = rem_sh >= {1'b0, divisor};
        rem_next = ge ? 13'(rem_sh - {1'b0, divisor}) : rem_sh[12:0];
        dvd_next = {dvd_reg[bqr_pkg::DIV_W-2:0], ge};
    end

    // Load on start, advance one bit per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign quot = dvd_reg;

endmodule

// ----- src/bqr_dp.sv -----
// ----------------------------------------------------------------------------
// bqr_dp
// Datapath: target and start registers, ramp multiply/divide, shared
// multiplier, term and accumulator registers, filter history and the output
// register.
// ----------------------------------------------------------------------------
module bqr_dp #(
    parameter int MAX_BLOCK = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bqr_pkg::dp_cmd_t    cmd,
    output bqr_pkg::dp_stat_t   stat,
    input  bqr_pkg::smp_item_t  smp_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                res_valid,
    input  logic                res_stall,
    output bqr_pkg::res_item_t  res_data
);

    localparam int IW = (MAX_BLOCK >= 8192) ? 13 :
                        ((MAX_BLOCK < 2) ? 1 : $clog2(MAX_BLOCK));

    logic signed [31:0] tgt_coef_reg [bqr_pkg::NUM_COEF];
    logic [23:0]        tgt_gain_reg;
    logic signed [31:0] start_coef_reg [bqr_pkg::NUM_COEF];
    logic [23:0]        start_gain_reg;
    logic signed [31:0] cur_coef_reg [bqr_pkg::NUM_COEF];
    logic [23:0]        cur_gain_reg;

    logic signed [23:0] x_reg;
    logic [12:0]        len_reg;
    logic               last_reg;
    logic [IW-1:0]      idx_reg;

    logic signed [23:0] prev_in1_reg;
    logic signed [23:0] prev_in2_reg;
    logic signed [39:0] prev_out1_reg;
    logic signed [39:0] prev_out2_reg;

    logic signed [58:0] prod_reg;
    logic signed [73:0] term_reg;
    logic signed [44:0] acc_reg;
    logic signed [39:0] y_reg;
    logic               pneg_reg;

    logic               res_valid_reg;
    bqr_pkg::res_item_t res_data_reg;

    logic [12:0]        len_c;
    logic [2:0]         ci;
    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [33:0] diff;
    logic [IW:0]        k;
    logic signed [23:0] xsrc;
    logic signed [39:0] ysrc;
    logic [58:0]        mag;
    logic [bqr_pkg::DIV_W-1:0] dividend;
    logic [bqr_pkg::DIV_W-1:0] quot;
    logic signed [33:0] wb_base;
    logic signed [33:0] wb_val;
    logic signed [39:0] y_sat;
    logic signed [23:0] o_sat;

    // Clamp the block length and flag the block's last sample
    always_comb
    begin
        if (32'(smp_data.block_length) > MAX_BLOCK)
            len_c = 13'(MAX_BLOCK);
        else
            len_c = smp_data.block_length;
    end

    assign stat.len_zero = smp_data.block_length == 13'd0;
    assign stat.last     = last_reg;

    // Select multiplier operands
    always_comb
    begin
        ci   = (cmd.sel < 3'(bqr_pkg::REG_GAIN)) ? cmd.sel : 3'd0;
        k    = (IW+1)'(idx_reg) + (IW+1)'(1);
        xsrc = (cmd.sel == 3'(bqr_pkg::REG_B0)) ? x_reg :
               (cmd.sel == 3'(bqr_pkg::REG_B1)) ? prev_in1_reg : prev_in2_reg;
        ysrc = (cmd.sel == 3'(bqr_pkg::REG_A1)) ? prev_out1_reg : prev_out2_reg;
        if (cmd.sel == 3'(bqr_pkg::REG_GAIN))
            diff = $signed(34'(tgt_gain_reg)) - $signed(34'(start_gain_reg));
        else
            diff = 34'(tgt_coef_reg[ci]) - 34'(start_coef_reg[ci]);
        mul_a = 34'(cur_coef_reg[ci]);
        mul_b = '0;
        case (cmd.mul_sel)
            bqr_pkg::MS_RAMP:
            begin
                mul_a = diff;
                mul_b = $signed(25'(k));
            end
            bqr_pkg::MS_CX:  mul_b = 25'(xsrc);
            bqr_pkg::MS_CYH: mul_b = 25'($signed(ysrc[39:16]));
            bqr_pkg::MS_CYL: mul_b = $signed({9'b0, ysrc[15:0]});
            bqr_pkg::MS_GYH:
            begin
                mul_a = $signed({10'b0, cur_gain_reg});
                mul_b = 25'($signed(y_reg[39:16]));
            end
            bqr_pkg::MS_GYL:
            begin
                mul_a = $signed({10'b0, cur_gain_reg});
                mul_b = $signed({9'b0, y_reg[15:0]});
            end
            default: mul_b = '0;
        endcase
    end

    // Ramp dividend: magnitude plus half the divisor for round to nearest
    always_comb
    begin
        mag      = prod_reg[58] ? 59'(-prod_reg) : 59'(prod_reg);
        dividend = bqr_pkg::DIV_W'(mag) + bqr_pkg::DIV_W'(len_reg >> 1);
    end

    bqr_div u_div (
        .clk      (clk),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (dividend),
        .divisor  (len_reg),
        .quot     (quot)
    );

    // Ramped value: start moved toward target by the rounded quotient
    always_comb
    begin
        if (cmd.sel == 3'(bqr_pkg::REG_GAIN))
            wb_base = $signed(34'(start_gain_reg));
        else
            wb_base = 34'(start_coef_reg[ci]);
        wb_val = pneg_reg ? wb_base - $signed(quot[33:0]) : wb_base + $signed(quot[33:0]);
    end

    // Saturate the filter sum and the scaled output
    always_comb
    begin
        if (acc_reg[44:39] != {6{acc_reg[44]}})
            y_sat = acc_reg[44] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
        else
            y_sat = acc_reg[39:0];
        if (term_reg[73:39] != {35{term_reg[73]}})
            o_sat = term_reg[73] ? {1'b1, 23'b0} : {1'b0, {23{1'b1}}};
        else
            o_sat = term_reg[39:16];
    end

    // Hold targets and ramp start values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bqr_pkg::NUM_COEF; i++)
            begin
                tgt_coef_reg[i]   <= (i == 0) ? 32'sh4000_0000 : 32'sd0;
                start_coef_reg[i] <= (i == 0) ? 32'sh4000_0000 : 32'sd0;
            end
            tgt_gain_reg   <= 24'd65536;
            start_gain_reg <= 24'd65536;
        end
        else
        begin
            if (cfg_we)
            begin
                case (bqr_pkg::reg_idx_t'(cfg_index))
                    bqr_pkg::REG_B0,
                    bqr_pkg::REG_B1,
                    bqr_pkg::REG_B2,
                    bqr_pkg::REG_A1,
                    bqr_pkg::REG_A2: tgt_coef_reg[cfg_index] <= cfg_data;
                    bqr_pkg::REG_GAIN: tgt_gain_reg <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (cmd.commit && last_reg)
            begin
                for (int i = 0; i < bqr_pkg::NUM_COEF; i++)
                    start_coef_reg[i] <= tgt_coef_reg[i];
                start_gain_reg <= tgt_gain_reg;
            end
        end
    end

    // Filter history, block position and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_in1_reg  <= '0;
            prev_in2_reg  <= '0;
            prev_out1_reg <= '0;
            prev_out2_reg <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                prev_in2_reg  <= prev_in1_reg;
                prev_in1_reg  <= x_reg;
                prev_out2_reg <= prev_out1_reg;
                prev_out1_reg <= y_reg;
                idx_reg       <= last_reg ? '0 : idx_reg + IW'(1);
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= smp_data.sample_in;
            len_reg  <= len_c;
            last_reg <= 14'(idx_reg) >= (14'(len_c) - 14'd1);
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.div_start)
            pneg_reg <= prod_reg[58];
        if (cmd.ramp_wb)
        begin
            if (cmd.sel == 3'(bqr_pkg::REG_GAIN))
                cur_gain_reg <= wb_val[23:0];
            else
                cur_coef_reg[ci] <= wb_val[31:0];
        end
        if (cmd.take_tgt)
        begin
            for (int i = 0; i < bqr_pkg::NUM_COEF; i++)
                cur_coef_reg[i] <= tgt_coef_reg[i];
            cur_gain_reg <= tgt_gain_reg;
        end
        case (cmd.term_op)
            bqr_pkg::TERM_SET:    term_reg <= 74'(prod_reg);
            bqr_pkg::TERM_SET_HI: term_reg <= 74'(prod_reg) <<< 16;
            bqr_pkg::TERM_ADD:    term_reg <= term_reg + 74'(prod_reg);
            default: ;
        endcase
        case (cmd.acc_op)
            bqr_pkg::ACC_CLR: acc_reg <= '0;
            bqr_pkg::ACC_ADD: acc_reg <= acc_reg + 45'(term_reg >>> 30);
            bqr_pkg::ACC_SUB: acc_reg <= acc_reg - 45'(term_reg >>> 30);
            default: ;
        endcase
        if (cmd.y_sat)
            y_reg <= y_sat;
        if (cmd.commit)
        begin
            res_data_reg.sample_out <= o_sat;
            res_data_reg.block_end  <= last_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ----- src/bqr_ctrl.sv -----
// ----------------------------------------------------------------------------
// bqr_ctrl
// Sequencer: ramps the six values one at a time through the multiplier and divider
// (or loads the targets on a block's last sample), then runs the five filter terms and the output scaling.
// ----------------------------------------------------------------------------
module bqr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              smp_valid,
    output logic              smp_stall,
    input  logic              res_valid,
    input  logic              res_stall,
    input  bqr_pkg::dp_stat_t stat,
    output bqr_pkg::dp_cmd_t  cmd
);

    bqr_pkg::state_t          state_reg;
    bqr_pkg::state_t          state_next;
    logic [2:0]               sel_reg;
    logic [2:0]               sel_next;
    logic                     half_reg;
    logic                     half_next;
    logic [bqr_pkg::CNT_W-1:0] cnt_reg;
    logic [bqr_pkg::CNT_W-1:0] cnt_next;
    logic                     fb_term;

    assign fb_term = sel_reg >= 3'(bqr_pkg::REG_A1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        half_next  = half_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            bqr_pkg::ST_IDLE:
                if (smp_valid && !stat.len_zero)
                    state_next = bqr_pkg::ST_SETUP;
            bqr_pkg::ST_SETUP:
            begin
                sel_next   = 3'(bqr_pkg::REG_B0);
                half_next  = 1'b0;
                state_next = stat.last ? bqr_pkg::ST_FMUL : bqr_pkg::ST_RMUL;
            end
            bqr_pkg::ST_RMUL:
                state_next = bqr_pkg::ST_RDIV_LD;
            bqr_pkg::ST_RDIV_LD:
            begin
                cnt_next   = '0;
                state_next = bqr_pkg::ST_RDIV;
            end
            bqr_pkg::ST_RDIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == bqr_pkg::CNT_W'(bqr_pkg::DIV_W - 1))
                    state_next = bqr_pkg::ST_RWB;
            end
            bqr_pkg::ST_RWB:
            begin
                if (sel_reg == 3'(bqr_pkg::REG_GAIN))
                begin
                    sel_next   = 3'(bqr_pkg::REG_B0);
                    state_next = bqr_pkg::ST_FMUL;
                end
                else
                begin
                    sel_next   = sel_reg + 3'd1;
                    state_next = bqr_pkg::ST_RMUL;
                end
            end
            bqr_pkg::ST_FMUL:
                state_next = bqr_pkg::ST_FTERM;
            bqr_pkg::ST_FTERM:
            begin
                if (fb_term && !half_reg)
                begin
                    half_next  = 1'b1;
                    state_next = bqr_pkg::ST_FMUL;
                end
                else
                begin
                    half_next  = 1'b0;
                    state_next = (sel_reg == 3'(bqr_pkg::REG_GAIN)) ?
                                 bqr_pkg::ST_OUT : bqr_pkg::ST_FACC;
                end
            end
            bqr_pkg::ST_FACC:
            begin
                if (sel_reg == 3'(bqr_pkg::REG_A2))
                    state_next = bqr_pkg::ST_YSAT;
                else
                begin
                    sel_next   = sel_reg + 3'd1;
                    state_next = bqr_pkg::ST_FMUL;
                end
            end
            bqr_pkg::ST_YSAT:
            begin
                sel_next   = 3'(bqr_pkg::REG_GAIN);
                half_next  = 1'b0;
                state_next = bqr_pkg::ST_FMUL;
            end
            bqr_pkg::ST_OUT:
                if (!res_valid || !res_stall)
                    state_next = bqr_pkg::ST_IDLE;
            default:
                state_next = bqr_pkg::ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd         = '0;
        cmd.sel     = sel_reg;
        cmd.mul_sel = bqr_pkg::MS_RAMP;
        cmd.term_op = bqr_pkg::TERM_HOLD;
        cmd.acc_op  = bqr_pkg::ACC_HOLD;
        case (state_reg)
            bqr_pkg::ST_IDLE:
                cmd.load = smp_valid && !stat.len_zero;
            bqr_pkg::ST_SETUP:
            begin
                cmd.acc_op   = bqr_pkg::ACC_CLR;
                cmd.take_tgt = stat.last;
            end
            bqr_pkg::ST_RMUL:
                cmd.mul_en = 1'b1;
            bqr_pkg::ST_RDIV_LD:
                cmd.div_start = 1'b1;
            bqr_pkg::ST_RDIV:
                cmd.div_step = 1'b1;
            bqr_pkg::ST_RWB:
                cmd.ramp_wb = 1'b1;
            bqr_pkg::ST_FMUL:
            begin
                cmd.mul_en = 1'b1;
                if (sel_reg == 3'(bqr_pkg::REG_GAIN))
                    cmd.mul_sel = half_reg ? bqr_pkg::MS_GYL : bqr_pkg::MS_GYH;
                else if (fb_term)
                    cmd.mul_sel = half_reg ? bqr_pkg::MS_CYL : bqr_pkg::MS_CYH;
                else
                    cmd.mul_sel = bqr_pkg::MS_CX;
            end
            bqr_pkg::ST_FTERM:
            begin
                if (!fb_term)
                    cmd.term_op = bqr_pkg::TERM_SET;
                else
                    cmd.term_op = half_reg ? bqr_pkg::TERM_ADD : bqr_pkg::TERM_SET_HI;
            end
            bqr_pkg::ST_FACC:
                cmd.acc_op = fb_term ? bqr_pkg::ACC_SUB : bqr_pkg::ACC_ADD;
            bqr_pkg::ST_YSAT:
                cmd.y_sat = 1'b1;
            bqr_pkg::ST_OUT:
                cmd.commit = !res_valid || !res_stall;
            default: ;
        endcase
    end

    assign smp_stall = state_reg != bqr_pkg::ST_IDLE;

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bqr_pkg::ST_IDLE;
            sel_reg   <= '0;
            half_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            half_reg  <= half_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- src/biquad_with_coefficient_ramp.sv -----
// ----------------------------------------------------------------------------
// biquad_with_coefficient_ramp
// Direct-form-1 biquad with output gain; coefficients and gain ramp linearly
// across each block and land on the configured targets at its last sample.
//
//   channel  signals                          direction  contents
//   smp      smp_valid smp_stall smp_data     in         sample_in, block_length
//   res      res_valid res_stall res_data     out        sample_out, block_end
//   cfg      cfg_we cfg_index cfg_data        in         b0 b1 b2 a1 a2 gain
//
// On a block's last sample the coefficients and gain load from the targets; any
// other sample first runs six ramp steps (multiply, divider load, 47 one-bit
// divide steps, write-back). Filter terms share one 34x25 multiplier: a
// feedforward term is one product; feedback terms and gain use high/low halves.
// A sample with zero block length is taken and dropped.
// The next sample is taken while a finished result waits on res_stall.
// Reset loads the default targets and clears history and block position.
// ----------------------------------------------------------------------------
module biquad_with_coefficient_ramp #(
    parameter int MAX_BLOCK = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               smp_valid,
    output logic               smp_stall,
    input  bqr_pkg::smp_item_t smp_data,
    output logic               res_valid,
    input  logic               res_stall,
    output bqr_pkg::res_item_t res_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    bqr_pkg::dp_cmd_t  cmd;
    bqr_pkg::dp_stat_t stat;

    bqr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bqr_dp #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .smp_data  (smp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
